>>> hdl/ktnl_pkg.sv
`default_nettype none

package ktnl_pkg;

    localparam int CODE_BITS = 21;
    localparam int POS_BITS  = 13;
    localparam int SIZE_BITS = 12;
    localparam int SLOT_BITS = 6;
    localparam int CMD_BITS  = 2;
    localparam int CNT_BITS  = 7;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_NEAREST = 2'd1,
        CMD_CODE    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [CMD_BITS-1:0]  command;
        logic [SLOT_BITS-1:0] slot;
        logic [CODE_BITS-1:0] codepoint;
        logic [POS_BITS-1:0]  pos_x;
        logic [POS_BITS-1:0]  pos_y;
        logic [SIZE_BITS-1:0] size_w;
        logic [SIZE_BITS-1:0] size_h;
    } t_req;

    typedef struct packed {
        logic                 found;
        logic [CODE_BITS-1:0] key_code;
        logic [POS_BITS-1:0]  key_x;
        logic [POS_BITS-1:0]  key_y;
        logic [SIZE_BITS-1:0] key_w;
        logic [SIZE_BITS-1:0] key_h;
    } t_rsp;

    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] slot;
    } t_cell_wr;

    typedef struct packed {
        logic clear;
        logic sample;
        logic nearest;
    } t_scan_ctl;

endpackage

`default_nettype wire

>>> hdl/ktnl_cell.sv
`default_nettype none

module ktnl_cell
    import ktnl_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int INDEX      = 0
) (
    input  wire logic                  i_clk,
    input  wire t_cell_wr              i_wr,
    input  wire logic                  i_rotate,
    input  wire logic [CODE_BITS-1:0]  i_wr_code,
    input  wire logic [COORD_BITS-1:0] i_wr_cx,
    input  wire logic [COORD_BITS-1:0] i_wr_cy,
    input  wire logic [SIZE_BITS-1:0]  i_wr_w,
    input  wire logic [SIZE_BITS-1:0]  i_wr_h,
    input  wire logic [CODE_BITS-1:0]  i_nb_code,
    input  wire logic [COORD_BITS-1:0] i_nb_cx,
    input  wire logic [COORD_BITS-1:0] i_nb_cy,
    input  wire logic [SIZE_BITS-1:0]  i_nb_w,
    input  wire logic [SIZE_BITS-1:0]  i_nb_h,
    output logic      [CODE_BITS-1:0]  o_code,
    output logic      [COORD_BITS-1:0] o_cx,
    output logic      [COORD_BITS-1:0] o_cy,
    output logic      [SIZE_BITS-1:0]  o_w,
    output logic      [SIZE_BITS-1:0]  o_h
);

    logic [CODE_BITS-1:0]  r_code;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [SIZE_BITS-1:0]  r_w;
    logic [SIZE_BITS-1:0]  r_h;
    logic                  sel;

    assign sel = i_wr.we && (int'(i_wr.slot) == INDEX);

    always_ff @(posedge i_clk) begin
        if (sel) begin
            r_code <= i_wr_code;
            r_cx   <= i_wr_cx;
            r_cy   <= i_wr_cy;
            r_w    <= i_wr_w;
            r_h    <= i_wr_h;
        end else if (i_rotate) begin
            r_code <= i_nb_code;
            r_cx   <= i_nb_cx;
            r_cy   <= i_nb_cy;
            r_w    <= i_nb_w;
            r_h    <= i_nb_h;
        end
    end

    assign o_code = r_code;
    assign o_cx   = r_cx;
    assign o_cy   = r_cy;
    assign o_w    = r_w;
    assign o_h    = r_h;

endmodule

`default_nettype wire

>>> hdl/ktnl_scan.sv
`default_nettype none

module ktnl_scan
    import ktnl_pkg::*;
#(
    parameter int COORD_BITS = 13
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_scan_ctl             i_ctl,
    input  wire logic [COORD_BITS-1:0] i_qx,
    input  wire logic [COORD_BITS-1:0] i_qy,
    input  wire logic [CODE_BITS-1:0]  i_qcode,
    input  wire logic [CODE_BITS-1:0]  i_code,
    input  wire logic [COORD_BITS-1:0] i_cx,
    input  wire logic [COORD_BITS-1:0] i_cy,
    input  wire logic [SIZE_BITS-1:0]  i_w,
    input  wire logic [SIZE_BITS-1:0]  i_h,
    output logic                       o_have,
    output logic      [CODE_BITS-1:0]  o_code,
    output logic      [COORD_BITS-1:0] o_cx,
    output logic      [COORD_BITS-1:0] o_cy,
    output logic      [SIZE_BITS-1:0]  o_w,
    output logic      [SIZE_BITS-1:0]  o_h
);

    localparam int SQ_BITS = 2 * COORD_BITS;
    localparam int D_BITS  = SQ_BITS + 1;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [D_BITS-1:0]     sq_dist;
    logic                  better;

    logic                  r_a_valid;
    logic                  r_a_match;
    logic [SQ_BITS-1:0]    r_a_dx2;
    logic [SQ_BITS-1:0]    r_a_dy2;
    logic [CODE_BITS-1:0]  r_a_code;
    logic [COORD_BITS-1:0] r_a_cx;
    logic [COORD_BITS-1:0] r_a_cy;
    logic [SIZE_BITS-1:0]  r_a_w;
    logic [SIZE_BITS-1:0]  r_a_h;

    logic                  r_have;
    logic [D_BITS-1:0]     r_best_d;
    logic [CODE_BITS-1:0]  r_code;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [SIZE_BITS-1:0]  r_w;
    logic [SIZE_BITS-1:0]  r_h;

    assign dx = (i_qx >= i_cx) ? (i_qx - i_cx) : (i_cx - i_qx);
    assign dy = (i_qy >= i_cy) ? (i_qy - i_cy) : (i_cy - i_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_ctl.sample;
        end
        r_a_dx2  <= SQ_BITS'(dx) * SQ_BITS'(dx);
        r_a_dy2  <= SQ_BITS'(dy) * SQ_BITS'(dy);
        r_a_match <= (i_code == i_qcode);
        r_a_code <= i_code;
        r_a_cx   <= i_cx;
        r_a_cy   <= i_cy;
        r_a_w    <= i_w;
        r_a_h    <= i_h;
    end

    assign sq_dist = D_BITS'(r_a_dx2) + D_BITS'(r_a_dy2);

    always_comb begin
        if (i_ctl.nearest) begin
            better = !r_have || (sq_dist < r_best_d);
        end else begin
            better = !r_have && r_a_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have <= 1'b0;
        end else if (r_a_valid && better) begin
            r_have <= 1'b1;
        end
        if (!i_ctl.clear && r_a_valid && better) begin
            r_best_d <= sq_dist;
            r_code   <= r_a_code;
            r_cx     <= r_a_cx;
            r_cy     <= r_a_cy;
            r_w      <= r_a_w;
            r_h      <= r_a_h;
        end
    end

    assign o_have = r_have;
    assign o_code = r_code;
    assign o_cx   = r_cx;
    assign o_cy   = r_cy;
    assign o_w    = r_w;
    assign o_h    = r_h;

endmodule

`default_nettype wire

>>> hdl/key_table_nearest_and_code_lookup_unit.sv
// Channel   Direction  Signals                Handshake
// request   in         i_req                  taken when start is high and busy is low
// result    out        o_rsp                  valid for one cycle while o_strobe is high
// config    in         i_cfg_data             written when i_cfg_we is high
//
// A write or an unknown command gives its result in the cycle after it is taken.
// A query rotates the ring of key cells once past the distance unit while scanning;
// then a flush state drains the pipeline and a finish state registers the result.
// Busy stays high through these states, and the result strobe follows the finish.
// Reset clears the key count and the control state; table contents are kept.
// The receiver cannot stall, so every result is shown once and then dropped.
`default_nettype none

module key_table_nearest_and_code_lookup_unit
    import ktnl_pkg::*;
#(
    parameter int MAX_KEYS   = 64,
    parameter int COORD_BITS = 13
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire t_req                i_req,
    output t_rsp                     o_rsp,
    output logic                     o_strobe,
    input  wire logic                i_cfg_we,
    input  wire logic [CNT_BITS-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int NW = (CW > CNT_BITS) ? CW : CNT_BITS;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_step, n_step;
    logic                  r_mode, n_mode;
    logic [COORD_BITS-1:0] r_qx, n_qx;
    logic [COORD_BITS-1:0] r_qy, n_qy;
    logic [CODE_BITS-1:0]  r_qcode, n_qcode;
    logic [CNT_BITS-1:0]   r_count;
    t_rsp                  r_rsp, n_rsp;
    logic                  r_strobe, n_strobe;

    logic                  accept;
    logic                  slot_ok;
    logic [NW-1:0]         active;
    logic [COORD_BITS-1:0] in_x;
    logic [COORD_BITS-1:0] in_y;
    t_cell_wr              wr;
    t_scan_ctl             sctl;

    logic [CODE_BITS-1:0]  c_code [MAX_KEYS];
    logic [COORD_BITS-1:0] c_cx   [MAX_KEYS];
    logic [COORD_BITS-1:0] c_cy   [MAX_KEYS];
    logic [SIZE_BITS-1:0]  c_w    [MAX_KEYS];
    logic [SIZE_BITS-1:0]  c_h    [MAX_KEYS];

    logic                  b_have;
    logic [CODE_BITS-1:0]  b_code;
    logic [COORD_BITS-1:0] b_cx;
    logic [COORD_BITS-1:0] b_cy;
    logic [SIZE_BITS-1:0]  b_w;
    logic [SIZE_BITS-1:0]  b_h;

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign slot_ok = NW'(i_req.slot) < NW'(MAX_KEYS);
    assign active  = (NW'(r_count) > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(r_count);
    assign in_x    = COORD_BITS'(i_req.pos_x);
    assign in_y    = COORD_BITS'(i_req.pos_y);

    assign wr.we   = accept && (t_cmd'(i_req.command) == CMD_WRITE) && slot_ok;
    assign wr.slot = i_req.slot;

    assign sctl.clear   = accept;
    assign sctl.sample  = (r_state == ST_SCAN) && (NW'(r_step) < active);
    assign sctl.nearest = r_mode;

    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        localparam int NB = (g + 1) % MAX_KEYS;
        ktnl_cell #(
            .COORD_BITS(COORD_BITS),
            .INDEX     (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_wr     (wr),
            .i_rotate (r_state == ST_SCAN),
            .i_wr_code(i_req.codepoint),
            .i_wr_cx  (in_x),
            .i_wr_cy  (in_y),
            .i_wr_w   (i_req.size_w),
            .i_wr_h   (i_req.size_h),
            .i_nb_code(c_code[NB]),
            .i_nb_cx  (c_cx[NB]),
            .i_nb_cy  (c_cy[NB]),
            .i_nb_w   (c_w[NB]),
            .i_nb_h   (c_h[NB]),
            .o_code   (c_code[g]),
            .o_cx     (c_cx[g]),
            .o_cy     (c_cy[g]),
            .o_w      (c_w[g]),
            .o_h      (c_h[g])
        );
    end

    ktnl_scan #(
        .COORD_BITS(COORD_BITS)
    ) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (sctl),
        .i_qx   (r_qx),
        .i_qy   (r_qy),
        .i_qcode(r_qcode),
        .i_code (c_code[0]),
        .i_cx   (c_cx[0]),
        .i_cy   (c_cy[0]),
        .i_w    (c_w[0]),
        .i_h    (c_h[0]),
        .o_have (b_have),
        .o_code (b_code),
        .o_cx   (b_cx),
        .o_cy   (b_cy),
        .o_w    (b_w),
        .o_h    (b_h)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
        end
        r_mode  <= n_mode;
        r_qx    <= n_qx;
        r_qy    <= n_qy;
        r_qcode <= n_qcode;
        r_rsp   <= n_rsp;
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_mode   = r_mode;
        n_qx     = r_qx;
        n_qy     = r_qy;
        n_qcode  = r_qcode;
        n_rsp    = r_rsp;
        n_strobe = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_qx    = in_x;
                    n_qy    = in_y;
                    n_qcode = i_req.codepoint;
                    n_step  = '0;
                    n_rsp   = '0;
                    case (t_cmd'(i_req.command))
                        CMD_WRITE: begin
                            n_strobe = 1'b1;
                            if (slot_ok) begin
                                n_rsp.found    = 1'b1;
                                n_rsp.key_code = i_req.codepoint;
                                n_rsp.key_x    = POS_BITS'(in_x);
                                n_rsp.key_y    = POS_BITS'(in_y);
                                n_rsp.key_w    = i_req.size_w;
                                n_rsp.key_h    = i_req.size_h;
                            end
                        end
                        CMD_NEAREST: begin
                            n_mode  = 1'b1;
                            n_state = ST_SCAN;
                        end
                        CMD_CODE: begin
                            n_mode  = 1'b0;
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_step = r_step + 1'b1;
                if (r_step == IW'(MAX_KEYS - 1)) begin
                    n_step  = '0;
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                n_state  = ST_IDLE;
                n_strobe = 1'b1;
                n_rsp    = '0;
                if (b_have) begin
                    n_rsp.found    = 1'b1;
                    n_rsp.key_code = b_code;
                    n_rsp.key_x    = POS_BITS'(b_cx);
                    n_rsp.key_y    = POS_BITS'(b_cy);
                    n_rsp.key_w    = b_w;
                    n_rsp.key_h    = b_h;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp    = r_rsp;
    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

>>> sim/key_table_nearest_and_code_lookup_unit_test.sv
`default_nettype none

module key_table_nearest_and_code_lookup_unit_test import ktnl_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_KEYS    = 64;
    localparam int POS_MAX     = 8191;
    localparam int SIZE_MAX    = 4095;
    localparam int CODE_MAX    = 'h10FFFF;
    localparam int PRINT_LIMIT = 30;
    localparam int PHASE_ITEMS = 220;
    localparam logic [CMD_BITS-1:0] CMD_UNKNOWN = 2'd3;

    // Mirrors the key table and holds the answers that are still owed by the block.
    class key_lookup_tracker;
        bit [CODE_BITS-1:0] code_tab [MAX_KEYS];
        bit [POS_BITS-1:0]  cx_tab   [MAX_KEYS];
        bit [POS_BITS-1:0]  cy_tab   [MAX_KEYS];
        bit [SIZE_BITS-1:0] w_tab    [MAX_KEYS];
        bit [SIZE_BITS-1:0] h_tab    [MAX_KEYS];
        bit                 written  [MAX_KEYS];
        bit [CNT_BITS-1:0]  keys_in_use;
        t_rsp               awaited[$];
        int                 mismatch_count;
        int                 answers_seen;

        function int active_keys();
            return (keys_in_use > MAX_KEYS) ? MAX_KEYS : int'(keys_in_use);
        endfunction

        function int written_prefix();
            int k;
            k = 0;
            while (k < MAX_KEYS && written[k]) k++;
            return k;
        endfunction

        function t_rsp entry_at(int idx);
            t_rsp e;
            e.found    = 1'b1;
            e.key_code = code_tab[idx];
            e.key_x    = cx_tab[idx];
            e.key_y    = cy_tab[idx];
            e.key_w    = w_tab[idx];
            e.key_h    = h_tab[idx];
            return e;
        endfunction

        function t_rsp lookup_key(t_req r);
            t_rsp        e;
            int          n, i, best, ax, ay, bx, by;
            longint      dx, dy, d, best_d;
            e      = '0;
            n      = active_keys();
            best   = -1;
            best_d = 0;
            bx     = r.pos_x;
            by     = r.pos_y;
            case (r.command)
                CMD_WRITE: begin
                    code_tab[r.slot] = r.codepoint;
                    cx_tab[r.slot]   = r.pos_x;
                    cy_tab[r.slot]   = r.pos_y;
                    w_tab[r.slot]    = r.size_w;
                    h_tab[r.slot]    = r.size_h;
                    written[r.slot]  = 1'b1;
                    e = entry_at(r.slot);
                end
                CMD_NEAREST: begin
                    for (i = 0; i < n; i++) begin
                        ax = cx_tab[i];
                        ay = cy_tab[i];
                        dx = (ax > bx) ? ax - bx : bx - ax;
                        dy = (ay > by) ? ay - by : by - ay;
                        d  = dx * dx + dy * dy;
                        if (best < 0 || d < best_d) begin
                            best   = i;
                            best_d = d;
                        end
                    end
                    if (best >= 0) e = entry_at(best);
                end
                CMD_CODE: begin
                    for (i = 0; i < n; i++) begin
                        if (code_tab[i] == r.codepoint) begin
                            e = entry_at(i);
                            break;
                        end
                    end
                end
                default: begin
                end
            endcase
            return e;
        endfunction

        function void take_request(t_req r);
            awaited.push_back(lookup_key(r));
        endfunction

        task flag_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                flag_mismatch($sformatf("answer %0d: %s is %0h, expected %0h",
                                        answers_seen, name, got, want));
        endtask

        task match_answer(t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                flag_mismatch($sformatf("answer %0d arrived with no request waiting",
                                        answers_seen));
            end else begin
                want = awaited.pop_front();
                compare_field("found", got.found, want.found);
                compare_field("key_code", got.key_code, want.key_code);
                compare_field("key_x", got.key_x, want.key_x);
                compare_field("key_y", got.key_y, want.key_y);
                compare_field("key_w", got.key_w, want.key_w);
                compare_field("key_h", got.key_h, want.key_h);
            end
            answers_seen++;
        endtask
    endclass

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                start      = 1'b0;
    logic                busy;
    t_req                i_req      = '0;
    t_rsp                o_rsp;
    logic                o_strobe;
    logic                i_cfg_we   = 1'b0;
    logic [CNT_BITS-1:0] i_cfg_data = '0;

    key_lookup_tracker tracker = new();

    key_table_nearest_and_code_lookup_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_strobe   (o_strobe),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) tracker.match_answer(o_rsp);
            if (start && busy === 1'b0) tracker.take_request(i_req);
        end
    end

    function automatic int clamp_pos(int v);
        return (v < 0) ? 0 : ((v > POS_MAX) ? POS_MAX : v);
    endfunction

    function automatic int random_code();
        case ($urandom_range(0, 3))
            0:       return 'h41 + $urandom_range(0, 7);
            1:       return $urandom_range(0, 1) * CODE_MAX;
            default: return $urandom_range(0, CODE_MAX);
        endcase
    endfunction

    function automatic t_req write_req(int slot, int code, int x, int y, int w, int h);
        t_req r;
        r.command   = CMD_WRITE;
        r.slot      = SLOT_BITS'(slot);
        r.codepoint = CODE_BITS'(code);
        r.pos_x     = POS_BITS'(x);
        r.pos_y     = POS_BITS'(y);
        r.size_w    = SIZE_BITS'(w);
        r.size_h    = SIZE_BITS'(h);
        return r;
    endfunction

    function automatic t_req query_req(logic [CMD_BITS-1:0] cmd, int code, int x, int y);
        t_req r;
        r           = '0;
        r.command   = cmd;
        r.codepoint = CODE_BITS'(code);
        r.pos_x     = POS_BITS'(x);
        r.pos_y     = POS_BITS'(y);
        return r;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   n, j, mode, pick;
        n           = tracker.active_keys();
        j           = (n > 0) ? $urandom_range(0, n - 1) : 0;
        mode        = $urandom_range(0, 9);
        pick        = $urandom_range(0, 99);
        r.command   = CMD_WRITE;
        r.slot      = SLOT_BITS'($urandom_range(0, MAX_KEYS - 1));
        r.codepoint = CODE_BITS'(random_code());
        r.pos_x     = POS_BITS'($urandom_range(0, POS_MAX));
        r.pos_y     = POS_BITS'($urandom_range(0, POS_MAX));
        r.size_w    = SIZE_BITS'($urandom_range(0, SIZE_MAX));
        r.size_h    = SIZE_BITS'($urandom_range(0, SIZE_MAX));
        if (pick < 34) begin
            if (n > 0 && mode < 5) r.slot = SLOT_BITS'(j);
            if (mode >= 8) begin
                // A copied centre gives equal distances, so the earlier entry must win.
                r.pos_x = tracker.cx_tab[j];
                r.pos_y = tracker.cy_tab[j];
            end else if (mode == 7) begin
                r.pos_x = POS_BITS'($urandom_range(0, 1) * POS_MAX);
                r.pos_y = POS_BITS'($urandom_range(0, 1) * POS_MAX);
            end
        end else if (pick < 66) begin
            r.command = CMD_NEAREST;
            if (mode < 3) begin
                r.pos_x = tracker.cx_tab[j];
                r.pos_y = tracker.cy_tab[j];
            end else if (mode < 5) begin
                r.pos_x = POS_BITS'(clamp_pos(int'(tracker.cx_tab[j])
                                              + $urandom_range(0, 64) - 32));
                r.pos_y = POS_BITS'(clamp_pos(int'(tracker.cy_tab[j])
                                              + $urandom_range(0, 64) - 32));
            end else if (mode == 5) begin
                r.pos_x = POS_BITS'($urandom_range(0, 1) * POS_MAX);
                r.pos_y = POS_BITS'($urandom_range(0, 1) * POS_MAX);
            end
        end else if (pick < 96) begin
            r.command = CMD_CODE;
            if (mode < 6) r.codepoint = tracker.code_tab[j];
        end else begin
            r.command = CMD_UNKNOWN;
        end
        return r;
    endfunction

    task automatic send_request(t_req r, int idle_pct, bit hold);
        int gap;
        gap = 0;
        if (hold) begin
            start <= 1'b0;
            @(posedge i_clk);
            while (tracker.awaited.size() != 0) @(posedge i_clk);
        end else begin
            if ($urandom_range(0, 99) < idle_pct) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_KEYS + 8) : 1;
                while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
            end
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic set_keys_in_use(bit [CNT_BITS-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.keys_in_use = value;
    endtask

    int unsigned phase_counts[8] = '{64, 1, 127, 40, 65, 3, 100, 64};

    initial begin
        int p, k, idle_pct;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_keys_in_use(CNT_BITS'(0));

        // An empty table answers every query with nothing found.
        send_request(query_req(CMD_NEAREST, 0, 0, 0), 0, 1'b0);
        send_request(query_req(CMD_CODE, 0, POS_MAX, POS_MAX), 0, 1'b0);
        send_request(write_req(MAX_KEYS - 1, CODE_MAX, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX)
                     | {CMD_UNKNOWN, {($bits(t_req) - CMD_BITS){1'b1}}}, 0, 1'b0);
        send_request(write_req(MAX_KEYS - 1, CODE_MAX, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX),
                     0, 1'b0);
        send_request(write_req(0, 0, 0, 0, 0, 0), 0, 1'b0);
        send_request(write_req(1, 'h41, 100, 100, 20, 30), 0, 1'b0);
        send_request(write_req(2, 'h41, 300, 100, 40, 50), 0, 1'b0);
        send_request(write_req(3, CODE_MAX, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX), 0, 1'b0);
        set_keys_in_use(CNT_BITS'(4));
        send_request(query_req(CMD_NEAREST, 0, 200, 100), 0, 1'b0);
        send_request(query_req(CMD_NEAREST, 0, 0, 0), 0, 1'b0);
        send_request(query_req(CMD_NEAREST, 0, POS_MAX, POS_MAX), 0, 1'b0);
        send_request(query_req(CMD_NEAREST, 0, POS_MAX, 0), 0, 1'b0);
        send_request(query_req(CMD_CODE, 'h41, 0, 0), 0, 1'b0);
        send_request(query_req(CMD_CODE, CODE_MAX, 0, 0), 0, 1'b0);
        send_request(query_req(CMD_CODE, 0, 0, 0), 0, 1'b0);
        send_request(query_req(CMD_CODE, 'h42, 0, 0), 0, 1'b0);
        send_request(query_req(CMD_UNKNOWN, 0, 0, 0), 0, 1'b0);
        set_keys_in_use(CNT_BITS'(2));
        send_request(query_req(CMD_NEAREST, 0, POS_MAX, POS_MAX), 0, 1'b0);
        send_request(query_req(CMD_CODE, CODE_MAX, 0, 0), 0, 1'b0);

        // Every slot is filled before wider counts are searched.
        for (k = 0; k < MAX_KEYS; k++)
            send_request(write_req(k, random_code(), $urandom_range(0, POS_MAX),
                                   $urandom_range(0, POS_MAX), $urandom_range(0, SIZE_MAX),
                                   $urandom_range(0, SIZE_MAX)), 0, 1'b0);

        for (p = 0; p < 8; p++) begin
            set_keys_in_use(CNT_BITS'(phase_counts[p]));
            idle_pct = (p % 4 == 1) ? 65 : ((p % 4 == 3) ? 12 : 0);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_request(random_request(), idle_pct, $urandom_range(0, 59) == 0);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (MAX_KEYS + 8) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.awaited.size() == 0) begin
            $display("key_table_nearest_and_code_lookup_unit regression: pass");
        end else begin
            $display("key_table_nearest_and_code_lookup_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("key_table_nearest_and_code_lookup_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
